[design/assert_macros.svh]
// Shared assertion macros for the deque checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque check failed: same-cycle implication");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque check failed: next-cycle implication");

`endif

[design/bdq_pkg.sv]
`default_nettype none

package bdq_pkg;

    // Fixed port field widths
    localparam int REQ_W       = 3;
    localparam int PORT_WORD_W = 64;
    localparam int COUNT_W     = 5;
    localparam int STAT_W      = 2;

    // Request codes; any other code acts as status only
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STATUS     = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POP_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PUSH_FULL  = 2'd2;

    // Controller states
    typedef enum logic
    {
        ST_IDLE,
        ST_FETCH
    } state_t;

endpackage

`default_nettype wire

[design/bdq_req_if.sv]
`default_nettype none

// Request channel: request code and word to push
interface bdq_req_if;
    logic                                valid;
    logic                                ready;
    logic [bdq_pkg::REQ_W-1:0]           req_type;
    logic [bdq_pkg::PORT_WORD_W-1:0]     push_word;

    modport source (output valid, output req_type, output push_word, input ready);
    modport sink   (input valid, input req_type, input push_word, output ready);
endinterface

`default_nettype wire

[design/bdq_rsp_if.sv]
`default_nettype none

// Result channel: popped word, end words, count and status
interface bdq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [bdq_pkg::PORT_WORD_W-1:0]     popped_word;
    logic [bdq_pkg::PORT_WORD_W-1:0]     front_word;
    logic [bdq_pkg::PORT_WORD_W-1:0]     back_word;
    logic [bdq_pkg::COUNT_W-1:0]         fill_count;
    logic                                is_empty;
    logic [bdq_pkg::STAT_W-1:0]          status;

    modport source (output valid, output popped_word, output front_word, output back_word,
                    output fill_count, output is_empty, output status, input ready);
    modport sink   (input valid, input popped_word, input front_word, input back_word,
                    input fill_count, input is_empty, input status, output ready);
endinterface

`default_nettype wire

[design/bdq_ram.sv]
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module bdq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/bounded_double_ended_queue.sv]
// A push, a status request, or a pop that leaves at most one word gives its result from
// the output register; a pop that leaves two or more words first waits in the fetch state
// on the registered ring RAM read of the new end word, then gives its result.
// One request per cycle while the result slot is free; no request is taken during a fetch.
// Reset: front pointer, count and handshake state clear; ring contents are not cleared.
`default_nettype none

module bounded_double_ended_queue #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bdq_req_if.sink    req,
    bdq_rsp_if.source  rsp
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int OUT_W   = bdq_pkg::PORT_WORD_W;
    localparam int OUT_C_W = bdq_pkg::COUNT_W;

    // Ring index of ptr + off, with off at most DEPTH
    function automatic logic [PTR_W-1:0] add_mod(input logic [PTR_W-1:0] ptr,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(ptr) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Control registers
    bdq_pkg::state_t  state_reg, state_next;
    logic [PTR_W-1:0] front_ptr_reg, front_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             fetch_front_reg, fetch_front_next;
    logic             out_valid_reg, out_valid_next;

    // Cached end words and result payload
    logic [WORD_BITS-1:0]      front_cache_reg, front_cache_next;
    logic [WORD_BITS-1:0]      back_cache_reg, back_cache_next;
    logic [WORD_BITS-1:0]      out_popped_reg, out_popped_next;
    logic [WORD_BITS-1:0]      out_front_reg, out_front_next;
    logic [WORD_BITS-1:0]      out_back_reg, out_back_next;
    logic [CNT_W-1:0]          out_count_reg, out_count_next;
    logic [bdq_pkg::STAT_W-1:0] out_status_reg, out_status_next;

    // RAM port
    logic                 ram_we;
    logic [PTR_W-1:0]     ram_waddr;
    logic [PTR_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    // Request decode helpers
    logic                 accept;
    logic                 need_fetch;
    logic                 is_full;
    logic                 is_void;
    logic [WORD_BITS-1:0] wdata;
    logic [PTR_W-1:0]     front_dec;
    logic [PTR_W-1:0]     front_inc;
    logic [PTR_W-1:0]     tail_wr_idx;
    logic [PTR_W-1:0]     back_rd_idx;

    assign accept      = req.valid && req.ready;
    assign is_full     = (count_reg == CNT_W'(DEPTH));
    assign is_void     = (count_reg == '0);
    assign wdata       = req.push_word[WORD_BITS-1:0];
    assign front_dec   = (front_ptr_reg == '0) ? PTR_W'(DEPTH - 1) : front_ptr_reg - 1'b1;
    assign front_inc   = add_mod(front_ptr_reg, CNT_W'(1));
    assign tail_wr_idx = add_mod(front_ptr_reg, count_reg);
    assign back_rd_idx = add_mod(front_ptr_reg, count_reg - CNT_W'(2));

    bdq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                if (accept && need_fetch)
                begin
                    state_next = bdq_pkg::ST_FETCH;
                end
            end
            bdq_pkg::ST_FETCH:
            begin
                state_next = bdq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bdq_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs: take a request only when idle and the result slot frees up
    always_comb
    begin
        req.ready = 1'b0;
        unique case (state_reg)
            bdq_pkg::ST_IDLE:  req.ready = !out_valid_reg || rsp.ready;
            bdq_pkg::ST_FETCH: req.ready = 1'b0;
            default:           req.ready = 1'b0;
        endcase
    end

    // Read-modify-write datapath
    always_comb
    begin
        front_ptr_next   = front_ptr_reg;
        count_next       = count_reg;
        fetch_front_next = fetch_front_reg;
        front_cache_next = front_cache_reg;
        back_cache_next  = back_cache_reg;
        out_popped_next  = out_popped_reg;
        out_front_next   = out_front_reg;
        out_back_next    = out_back_reg;
        out_count_next   = out_count_reg;
        out_status_next  = out_status_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        ram_we           = 1'b0;
        ram_waddr        = tail_wr_idx;
        ram_raddr        = front_inc;
        need_fetch       = 1'b0;

        if (accept)
        begin
            out_popped_next = '0;
            out_status_next = bdq_pkg::STAT_OK;
            case (req.req_type)
                bdq_pkg::REQ_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        out_status_next = bdq_pkg::STAT_PUSH_FULL;
                    end
                    else
                    begin
                        ram_we           = 1'b1;
                        ram_waddr        = front_dec;
                        front_ptr_next   = front_dec;
                        count_next       = count_reg + CNT_W'(1);
                        front_cache_next = wdata;
                        if (is_void)
                        begin
                            back_cache_next = wdata;
                        end
                    end
                end
                bdq_pkg::REQ_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        out_status_next = bdq_pkg::STAT_PUSH_FULL;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = tail_wr_idx;
                        count_next      = count_reg + CNT_W'(1);
                        back_cache_next = wdata;
                        if (is_void)
                        begin
                            front_cache_next = wdata;
                        end
                    end
                end
                bdq_pkg::REQ_POP_FRONT:
                begin
                    if (is_void)
                    begin
                        out_status_next = bdq_pkg::STAT_POP_EMPTY;
                    end
                    else
                    begin
                        out_popped_next = front_cache_reg;
                        front_ptr_next  = front_inc;
                        count_next      = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(2))
                        begin
                            front_cache_next = back_cache_reg;
                        end
                        else if (count_reg > CNT_W'(2))
                        begin
                            need_fetch       = 1'b1;
                            fetch_front_next = 1'b1;
                            ram_raddr        = front_inc;
                        end
                    end
                end
                bdq_pkg::REQ_POP_BACK:
                begin
                    if (is_void)
                    begin
                        out_status_next = bdq_pkg::STAT_POP_EMPTY;
                    end
                    else
                    begin
                        out_popped_next = back_cache_reg;
                        count_next      = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(2))
                        begin
                            back_cache_next = front_cache_reg;
                        end
                        else if (count_reg > CNT_W'(2))
                        begin
                            need_fetch       = 1'b1;
                            fetch_front_next = 1'b0;
                            ram_raddr        = back_rd_idx;
                        end
                    end
                end
                default:
                begin
                    // status only, also for unused codes
                end
            endcase

            out_count_next = count_next;
            out_front_next = (count_next == '0) ? '0 : front_cache_next;
            out_back_next  = (count_next == '0) ? '0 : back_cache_next;
            out_valid_next = !need_fetch;
        end
        else if (state_reg == bdq_pkg::ST_FETCH)
        begin
            // new end word arrives from the ring
            if (fetch_front_reg)
            begin
                front_cache_next = ram_rdata;
                out_front_next   = ram_rdata;
            end
            else
            begin
                back_cache_next = ram_rdata;
                out_back_next   = ram_rdata;
            end
            out_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bdq_pkg::ST_IDLE;
            front_ptr_reg   <= '0;
            count_reg       <= '0;
            fetch_front_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            front_ptr_reg   <= front_ptr_next;
            count_reg       <= count_next;
            fetch_front_reg <= fetch_front_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        front_cache_reg <= front_cache_next;
        back_cache_reg  <= back_cache_next;
        out_popped_reg  <= out_popped_next;
        out_front_reg   <= out_front_next;
        out_back_reg    <= out_back_next;
        out_count_reg   <= out_count_next;
        out_status_reg  <= out_status_next;
    end

    // Result channel
    assign rsp.valid       = out_valid_reg;
    assign rsp.popped_word = OUT_W'(out_popped_reg);
    assign rsp.front_word  = OUT_W'(out_front_reg);
    assign rsp.back_word   = OUT_W'(out_back_reg);
    assign rsp.fill_count  = OUT_C_W'(out_count_reg);
    assign rsp.is_empty    = (out_count_reg == '0);
    assign rsp.status      = out_status_reg;

endmodule

`default_nettype wire

[design/bdq_checker.sv]
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the result channel
module bdq_checker #(
    parameter int DEPTH = 16
) (
    input wire logic  clk,
    input wire logic  rst_n,
    bdq_rsp_if.source rsp
);

    // A stalled result stays valid and holds its count and popped word
    `ASSERT_NEXT(a_hold_stalled, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.fill_count) && $stable(rsp.popped_word))

    // Empty flag agrees with the count
    `ASSERT_IMPLY(a_empty_flag, clk, rst_n, rsp.valid, rsp.is_empty == (rsp.fill_count == '0))

    // End words read as zero on an empty queue
    `ASSERT_IMPLY(a_empty_ends, clk, rst_n, rsp.valid && rsp.is_empty, rsp.front_word == '0 && rsp.back_word == '0)

    // Count never exceeds the ring size and status is a known code
    `ASSERT_IMPLY(a_count_range, clk, rst_n, rsp.valid, 32'(rsp.fill_count) <= DEPTH && (rsp.status == bdq_pkg::STAT_OK || rsp.status == bdq_pkg::STAT_POP_EMPTY || rsp.status == bdq_pkg::STAT_PUSH_FULL))

    // A failed pop removes nothing
    `ASSERT_IMPLY(a_failed_pop, clk, rst_n, rsp.valid && rsp.status == bdq_pkg::STAT_POP_EMPTY, rsp.popped_word == '0 && rsp.is_empty)

endmodule

bind bounded_double_ended_queue bdq_checker #(
    .DEPTH (DEPTH)
) u_bdq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .rsp   (rsp)
);

`default_nettype wire
